>>> design/afm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afm_pkg
// Shared types, register indexes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package afm_pkg;

  localparam int REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_IMPACT_THRESHOLD = 3'd0,
    REG_BAND_LOW         = 3'd1,
    REG_BAND_HIGH        = 3'd2,
    REG_UPRIGHT_LIMIT    = 3'd3,
    REG_VIB_WINDOW       = 3'd4,
    REG_MOVE_WINDOW      = 3'd5,
    REG_MOVE_THRESHOLD   = 3'd6,
    REG_STILL_LIMIT      = 3'd7
  } reg_idx_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SQ     = 6'b000010,
    S_RT_MAG = 6'b000100,
    S_RT_H   = 6'b001000,
    S_CORD   = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  localparam logic [3:0] LAST_STEP   = 4'd15;
  localparam logic [1:0] LAST_SQ     = 2'd2;
  localparam logic [10:0] TILT_RIGHT = 11'd900;
  localparam logic [10:0] TILT_FULL  = 11'd1800;

  // arctangent of 2^-i in 1/256 tenth degree
  function automatic logic [16:0] atan_lut(input logic [3:0] i);
    logic [16:0] r;
    case (i)
      4'd0:    r = 17'd115200;
      4'd1:    r = 17'd68007;
      4'd2:    r = 17'd35933;
      4'd3:    r = 17'd18240;
      4'd4:    r = 17'd9155;
      4'd5:    r = 17'd4582;
      4'd6:    r = 17'd2292;
      4'd7:    r = 17'd1146;
      4'd8:    r = 17'd573;
      4'd9:    r = 17'd286;
      4'd10:   r = 17'd143;
      4'd11:   r = 17'd72;
      4'd12:   r = 17'd36;
      4'd13:   r = 17'd18;
      4'd14:   r = 17'd9;
      4'd15:   r = 17'd4;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

>>> design/afm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afm_in_if / afm_out_if
// Valid/ready channels for accelerometer samples and monitor results.
// ----------------------------------------------------------------------------
interface afm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface afm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] magnitude;
  logic        impact;
  logic        tipped_over;
  logic        fallen_alert;
  logic [10:0] tilt_tenths;
  logic [15:0] vibration;
  logic        moving;
  logic [7:0]  still_streak;
  logic        move_window_end;
  modport source (output valid, magnitude, impact, tipped_over, fallen_alert, tilt_tenths,
                  vibration, moving, still_streak, move_window_end, input ready);
  modport sink   (input valid, magnitude, impact, tipped_over, fallen_alert, tilt_tenths,
                  vibration, moving, still_streak, move_window_end, output ready);
endinterface

>>> design/accel_fall_tilt_motion_monitor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_fall_tilt_motion_monitor_top
// Magnitude, impact, fall, tilt, vibration and motion from accelerometer data.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  in_ch    | in  | valid/ready   | accel_x, accel_y, accel_z (16s)
//  out_ch   | out | valid/ready   | magnitude .. move_window_end
//  cfg_*    | in  | APB, pready=1 | 8 registers at 4*i, 32-bit data
//
//  From transfer to result a sample goes through the multiplier squaring x, z, y,
//  16 steps of the shared square-root unit twice, 16 CORDIC steps, 1 update.
//  A new sample is taken only while the sequencer is idle; a finished result
//  waits in the output register while the next sample is worked on.
//  rst_n is synchronous, active low; it restores register defaults.
// ----------------------------------------------------------------------------
module accel_fall_tilt_motion_monitor_top #(
  parameter int COOLDOWN_SAMPLES = 150,
  parameter int TILT_MIN_MAG     = 410
) (
  input  logic        clk,
  input  logic        rst_n,
  afm_in_if.sink      in_ch,
  afm_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import afm_pkg::*;

  localparam logic [7:0]  COOL_LOAD = 8'(COOLDOWN_SAMPLES);
  localparam logic [15:0] TILT_MIN  = 16'(TILT_MIN_MAG);

  // configuration
  logic [15:0]        impact_thr_r, band_low_r, band_high_r, move_win_r, move_thr_r;
  logic signed [15:0] upright_r;
  logic [7:0]         vib_win_r, still_lim_r;
  reg_idx_t           widx;

  assign cfg_pready = 1'b1;
  assign widx = reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      impact_thr_r <= 16'd10240;
      band_low_r   <= 16'd2048;
      band_high_r  <= 16'd6144;
      upright_r    <= -16'sd1638;
      vib_win_r    <= 8'd25;
      move_win_r   <= 16'd300;
      move_thr_r   <= 16'd33;
      still_lim_r  <= 8'd10;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (widx)
        REG_IMPACT_THRESHOLD: impact_thr_r <= cfg_pwdata[15:0];
        REG_BAND_LOW:         band_low_r   <= cfg_pwdata[15:0];
        REG_BAND_HIGH:        band_high_r  <= cfg_pwdata[15:0];
        REG_UPRIGHT_LIMIT:    upright_r    <= signed'(cfg_pwdata[15:0]);
        REG_VIB_WINDOW:       vib_win_r    <= cfg_pwdata[7:0];
        REG_MOVE_WINDOW:      move_win_r   <= cfg_pwdata[15:0];
        REG_MOVE_THRESHOLD:   move_thr_r   <= cfg_pwdata[15:0];
        REG_STILL_LIMIT:      still_lim_r  <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_IMPACT_THRESHOLD: cfg_prdata = {16'd0, impact_thr_r};
      REG_BAND_LOW:         cfg_prdata = {16'd0, band_low_r};
      REG_BAND_HIGH:        cfg_prdata = {16'd0, band_high_r};
      REG_UPRIGHT_LIMIT:    cfg_prdata = {{16{upright_r[15]}}, upright_r};
      REG_VIB_WINDOW:       cfg_prdata = {24'd0, vib_win_r};
      REG_MOVE_WINDOW:      cfg_prdata = {16'd0, move_win_r};
      REG_MOVE_THRESHOLD:   cfg_prdata = {16'd0, move_thr_r};
      REG_STILL_LIMIT:      cfg_prdata = {24'd0, still_lim_r};
      default:              cfg_prdata = 32'd0;
    endcase
  end

  // sequencer and datapath
  state_t             state_r;
  logic [3:0]         step_r;
  logic signed [15:0] ax_r, ay_r, az_r;
  logic [31:0]        sum_all_r, sum_xz_r;
  logic [31:0]        rad_r;
  logic [16:0]        rem_r;
  logic [15:0]        root_r, mag_r;
  logic signed [31:0] cx_r, cy_r;
  logic signed [19:0] cz_r;

  // monitor state
  logic        fallen_r;
  logic [7:0]  cool_r;
  logic [10:0] tilt_r;
  logic [15:0] vpk_r, vtr_r, vhold_r, mpk_r, mtr_r, mcnt_r;
  logic [7:0]  vcnt_r, streak_r;
  logic        moving_r;

  // output register
  logic        ov_r;

  assign in_ch.ready = (state_r == S_IDLE);

  // multiplier operand
  logic signed [15:0] mop;
  logic signed [31:0] prod;
  always_comb begin
    case (step_r[1:0])
      2'd0:    mop = ax_r;
      2'd1:    mop = az_r;
      default: mop = ay_r;
    endcase
  end
  assign prod = mop * mop;

  // square-root step
  logic [18:0] rem_sh, trial, rdiff;
  logic        take;
  assign rem_sh = {rem_r, rad_r[31:30]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign rdiff  = rem_sh - trial;
  assign take   = (rem_sh >= trial);
  logic [15:0] root_nxt;
  logic [16:0] rem_nxt;
  assign root_nxt = {root_r[14:0], take};
  assign rem_nxt  = take ? rdiff[16:0] : rem_sh[16:0];

  // CORDIC step
  logic signed [31:0] shx, shy;
  logic signed [19:0] at;
  assign shx = cx_r >>> step_r;
  assign shy = cy_r >>> step_r;
  assign at  = signed'({3'b000, atan_lut(step_r)});

  // final angle
  logic signed [19:0] zr;
  logic [10:0]        ang, tilt_new;
  assign zr = (cz_r + 20'sd128) >>> 8;
  always_comb begin
    if (zr[19])                               ang = 11'd0;
    else if (zr > signed'({9'd0, TILT_RIGHT})) ang = TILT_RIGHT;
    else                                      ang = zr[10:0];
  end
  assign tilt_new = (ay_r > 16'sd0) ? (TILT_FULL - ang) : ang;

  // update-cycle logic
  logic        in_band, alert;
  logic [7:0]  cool_a;
  logic        fallen_n;
  logic [15:0] vpk_n, vtr_n, mpk_n, mtr_n, mdelta;
  logic [8:0]  vcnt_inc;
  logic [16:0] mcnt_inc;
  logic        vclose, mclose;
  logic [7:0]  streak_inc, streak_n;
  logic        moving_n;
  logic        do_done;

  assign do_done = (state_r == S_DONE) && (!ov_r || out_ch.ready);
  assign in_band = (mag_r > band_low_r) && (mag_r < band_high_r);

  always_comb begin
    fallen_n = fallen_r;
    cool_a   = cool_r;
    alert    = 1'b0;
    if (in_band) begin
      if (ay_r > upright_r) begin
        fallen_n = 1'b1;
        if (cool_r == 8'd0) begin
          alert  = 1'b1;
          cool_a = COOL_LOAD;
        end
      end else begin
        fallen_n = 1'b0;
        cool_a   = 8'd0;
      end
    end
  end

  assign vpk_n    = (mag_r > vpk_r) ? mag_r : vpk_r;
  assign vtr_n    = (mag_r < vtr_r) ? mag_r : vtr_r;
  assign mpk_n    = (mag_r > mpk_r) ? mag_r : mpk_r;
  assign mtr_n    = (mag_r < mtr_r) ? mag_r : mtr_r;
  assign vcnt_inc = {1'b0, vcnt_r} + 9'd1;
  assign mcnt_inc = {1'b0, mcnt_r} + 17'd1;
  assign vclose   = (vcnt_inc >= {1'b0, vib_win_r});
  assign mclose   = (mcnt_inc >= {1'b0, move_win_r});
  assign mdelta   = mpk_n - mtr_n;
  assign streak_inc = (streak_r < 8'd255) ? (streak_r + 8'd1) : streak_r;

  always_comb begin
    streak_n = streak_r;
    moving_n = moving_r;
    if (mclose) begin
      if (mdelta > move_thr_r) begin
        streak_n = 8'd0;
        moving_n = 1'b1;
      end else begin
        streak_n = streak_inc;
        if (streak_inc >= still_lim_r) moving_n = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      step_r   <= 4'd0;
      ov_r     <= 1'b0;
      fallen_r <= 1'b0;
      cool_r   <= 8'd0;
      tilt_r   <= 11'd0;
      vpk_r    <= 16'd0;
      vtr_r    <= 16'hFFFF;
      vcnt_r   <= 8'd0;
      vhold_r  <= 16'd0;
      mpk_r    <= 16'd0;
      mtr_r    <= 16'hFFFF;
      mcnt_r   <= 16'd0;
      streak_r <= 8'd0;
      moving_r <= 1'b0;
    end else begin
      if (do_done) ov_r <= 1'b1;
      else if (ov_r && out_ch.ready) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            ax_r      <= in_ch.accel_x;
            ay_r      <= in_ch.accel_y;
            az_r      <= in_ch.accel_z;
            sum_xz_r  <= 32'd0;
            sum_all_r <= 32'd0;
            step_r    <= 4'd0;
            state_r   <= S_SQ;
          end
        end
        S_SQ: begin
          // x and z first feed both sums, y only the full sum
          if (step_r[1:0] != LAST_SQ) sum_xz_r <= sum_xz_r + unsigned'(prod);
          if (step_r[1:0] == LAST_SQ) begin
            rad_r   <= sum_all_r + unsigned'(prod);
            rem_r   <= 17'd0;
            root_r  <= 16'd0;
            step_r  <= 4'd0;
            state_r <= S_RT_MAG;
          end else begin
            sum_all_r <= sum_all_r + unsigned'(prod);
            step_r    <= step_r + 4'd1;
          end
        end
        S_RT_MAG: begin
          step_r <= step_r + 4'd1;
          if (step_r == LAST_STEP) begin
            mag_r   <= root_nxt;
            rad_r   <= sum_xz_r;
            rem_r   <= 17'd0;
            root_r  <= 16'd0;
            state_r <= S_RT_H;
          end else begin
            rad_r  <= {rad_r[29:0], 2'b00};
            rem_r  <= rem_nxt;
            root_r <= root_nxt;
          end
        end
        S_RT_H: begin
          step_r <= step_r + 4'd1;
          if (step_r == LAST_STEP) begin
            cx_r    <= signed'({3'b000, (ay_r[15] ? 17'(-ay_r) : 17'(ay_r)), 12'd0});
            cy_r    <= signed'({4'b0000, root_nxt, 12'd0});
            cz_r    <= 20'sd0;
            state_r <= S_CORD;
          end else begin
            rad_r  <= {rad_r[29:0], 2'b00};
            rem_r  <= rem_nxt;
            root_r <= root_nxt;
          end
        end
        S_CORD: begin
          if (!cy_r[31]) begin
            cx_r <= cx_r + shy;
            cy_r <= cy_r - shx;
            cz_r <= cz_r + at;
          end else begin
            cx_r <= cx_r - shy;
            cy_r <= cy_r + shx;
            cz_r <= cz_r - at;
          end
          step_r <= step_r + 4'd1;
          if (step_r == LAST_STEP) state_r <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (do_done) begin
            fallen_r <= fallen_n;
            cool_r   <= (cool_a != 8'd0) ? (cool_a - 8'd1) : cool_a;
            if (mag_r >= TILT_MIN) tilt_r <= tilt_new;
            if (vclose) begin
              vhold_r <= vpk_n - vtr_n;
              vpk_r   <= 16'd0;
              vtr_r   <= 16'hFFFF;
              vcnt_r  <= 8'd0;
            end else begin
              vpk_r  <= vpk_n;
              vtr_r  <= vtr_n;
              vcnt_r <= vcnt_inc[7:0];
            end
            streak_r <= streak_n;
            moving_r <= moving_n;
            out_ch.magnitude    <= mag_r;
            out_ch.impact       <= (mag_r > impact_thr_r);
            out_ch.tipped_over  <= fallen_n;
            out_ch.fallen_alert <= alert;
            out_ch.tilt_tenths  <= (mag_r >= TILT_MIN) ? tilt_new : tilt_r;
            out_ch.vibration    <= vclose ? (vpk_n - vtr_n) : vhold_r;
            out_ch.move_window_end <= mclose;
            out_ch.moving       <= moving_n;
            out_ch.still_streak <= streak_n;
            if (mclose) begin
              mpk_r  <= 16'd0;
              mtr_r  <= 16'hFFFF;
              mcnt_r <= 16'd0;
            end else begin
              mpk_r  <= mpk_n;
              mtr_r  <= mtr_n;
              mcnt_r <= mcnt_inc[15:0];
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid = ov_r;

endmodule
